>>> hdl/ovn_pkg.sv
// shared constants and the lattice hash table for the octave value noise block
// no dependencies
package ovn_pkg;

  localparam int COORD_W = 24;
  localparam int FREQ_W  = 16;
  localparam int OCT_W   = 4;
  localparam int SEED_W  = 8;
  localparam int NOISE_W = 16;
  localparam int POS_W   = 32;   // scaled position, lattice byte in [31:24]
  localparam int FRAC_W  = 16;
  localparam int VAL_W   = 24;   // octave value, Q8.16
  localparam int CFG_W   = 16;
  localparam int CFG_A_W = 2;

  localparam logic [CFG_A_W-1:0] CFG_FREQUENCY = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_OCTAVES   = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_SEED      = 2'd2;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd197;
  localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd2;
  localparam logic [SEED_W-1:0] SEED_RESET = 8'd7;

  localparam logic [7:0] PERM_TAB [256] = '{
    8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
    8'd71,8'd48,8'd140,8'd254,8'd245,8'd255,8'd247,8'd247,8'd40,8'd185,8'd248,8'd251,
    8'd245,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,8'd28,8'd234,8'd163,
    8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,
    8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,
    8'd180,8'd204,8'd8,8'd81,8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,
    8'd177,8'd32,8'd81,8'd195,8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,
    8'd195,8'd13,8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,
    8'd181,8'd235,8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,8'd164,
    8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,8'd4,
    8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,8'd228,8'd108,8'd245,8'd148,
    8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,8'd215,8'd253,8'd65,8'd85,
    8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,8'd232,8'd50,8'd217,8'd64,8'd244,
    8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,8'd203,8'd149,8'd152,8'd140,8'd187,
    8'd234,8'd177,8'd73,8'd174,8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,
    8'd19,8'd103,8'd13,8'd90,8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,
    8'd145,8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,
    8'd79,8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,8'd135,
    8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,8'd142,
    8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,8'd114,8'd20,8'd218,8'd113,8'd154,
    8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,8'd250,8'd209,8'd92,8'd222,8'd173,
    8'd21,8'd88,8'd102,8'd219
  };

endpackage

>>> hdl/octave_value_noise_2d.sv
// top level of the octave value noise block: config registers, scaling, cell row, output
// depends on ovn_pkg, ovn_cell, ovn_norm
//
// usage
//   in_*  : one request per sample, in_tdata = coord_x [23:0], coord_y [47:24]
//   out_* : one noise sample per request, in request order, out_tdata = noise_value
//   cfg_* : plain register writes, index 0 frequency_scale, 1 octave_count,
//           2 seed_value; other indexes are ignored; write only while idle
// pipeline
//   one scaling multiply stage, then a row of MAX_OCTAVES identical octave
//   cells of five stages each, every cell passing its doubled position and
//   running sum to the next, then three normalization stages and the output
//   register: latency 5*MAX_OCTAVES+5 cycles (45 at the default)
//   throughput one request per cycle, set by the fully pipelined cell row
// reset
//   rst_n low clears all valid bits and loads the register defaults
//   (frequency 197, two octaves, seed 7)
// stall
//   when out_tready is low with a result held, the whole pipeline freezes and
//   in_tready drops; nothing is lost or repeated
module octave_value_noise_2d
  import ovn_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [47:0]        in_tdata,   // coord_x [23:0], coord_y [47:24]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,  // noise_value [15:0]
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int NW    = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W = VAL_W + MAX_OCTAVES;

  // configuration registers
  logic [FREQ_W-1:0] freq_r;
  logic [OCT_W-1:0]  oct_r;
  logic [SEED_W-1:0] seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= FREQ_RESET;
      oct_r  <= OCT_RESET;
      seed_r <= SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FREQUENCY: freq_r <= cfg_wdata[FREQ_W-1:0];
        CFG_OCTAVES:   oct_r  <= cfg_wdata[OCT_W-1:0];
        CFG_SEED:      seed_r <= cfg_wdata[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // octave count clamped to 1..MAX_OCTAVES
  logic [NW-1:0] oct_n;
  always_comb begin
    if (oct_r == '0) begin
      oct_n = NW'(1);
    end else if (int'(oct_r) > MAX_OCTAVES) begin
      oct_n = NW'(MAX_OCTAVES);
    end else begin
      oct_n = NW'(oct_r);
    end
  end

  // global advance: move when the output slot is free or being taken
  logic en;
  logic out_vld_r;
  logic [NOISE_W-1:0] out_data_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // scaling stage: position times frequency, kept to the low 32 bits
  logic             m_vld_r;
  logic [POS_W-1:0] m_px_r, m_py_r;
  logic [39:0]      bx, by;

  assign bx = {16'd0, in_tdata[23:0]} * {24'd0, freq_r};
  assign by = {16'd0, in_tdata[47:24]} * {24'd0, freq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_px_r <= bx[POS_W-1:0];
      m_py_r <= by[POS_W-1:0];
    end
  end

  // row of octave cells
  logic             c_vld [MAX_OCTAVES+1];
  logic [POS_W-1:0] c_px  [MAX_OCTAVES+1];
  logic [POS_W-1:0] c_py  [MAX_OCTAVES+1];
  logic [ACC_W-1:0] c_acc [MAX_OCTAVES+1];

  assign c_vld[0] = m_vld_r;
  assign c_px[0]  = m_px_r;
  assign c_py[0]  = m_py_r;
  assign c_acc[0] = '0;

  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_cell
    ovn_cell #(
      .IDX   (o),
      .NW    (NW),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .oct_n (oct_n),
      .seed  (seed_r),
      .vld_i (c_vld[o]),
      .px_i  (c_px[o]),
      .py_i  (c_py[o]),
      .acc_i (c_acc[o]),
      .vld_o (c_vld[o+1]),
      .px_o  (c_px[o+1]),
      .py_o  (c_py[o+1]),
      .acc_o (c_acc[o+1])
    );
  end

  // normalization
  logic               n_vld;
  logic [NOISE_W-1:0] n_q;

  ovn_norm #(
    .MAX_OCT (MAX_OCTAVES),
    .NW      (NW),
    .ACC_W   (ACC_W)
  ) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .oct_n (oct_n),
    .vld_i (c_vld[MAX_OCTAVES]),
    .acc_i (c_acc[MAX_OCTAVES]),
    .vld_o (n_vld),
    .q_o   (n_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= n_q;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // normalized noise never exceeds 255/256
  a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= 16'd65280))
    else $error("noise value above normalized range");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // a stall freezes the scaling stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(m_px_r) && $stable(m_vld_r)))
    else $error("pipeline moved during stall");

endmodule

>>> hdl/ovn_cell.sv
// one octave cell: lattice hash, smoothstep weights, bilinear blend, horner accumulate
// depends on ovn_pkg
module ovn_cell
  import ovn_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int NW    = 4,
  parameter int ACC_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [NW-1:0]    oct_n,
  input  logic [SEED_W-1:0] seed,
  input  logic             vld_i,
  input  logic [POS_W-1:0] px_i,
  input  logic [POS_W-1:0] py_i,
  input  logic [ACC_W-1:0] acc_i,
  output logic             vld_o,
  output logic [POS_W-1:0] px_o,
  output logic [POS_W-1:0] py_o,
  output logic [ACC_W-1:0] acc_o
);

  logic active;
  assign active = (IDX < int'(oct_n));

  // stage a: fraction squares and row hashes
  logic              a_vld_r;
  logic [POS_W-1:0]  a_px_r, a_py_r;
  logic [ACC_W-1:0]  a_acc_r;
  logic [FRAC_W-1:0] a_fx_r, a_fy_r, a_f2x_r, a_f2y_r;
  logic [7:0]        a_ix_r, a_row0_r, a_row1_r;
  logic [FRAC_W-1:0] fx, fy;
  logic [31:0]       sqx, sqy;
  logic [7:0]        iy, ry0, ry1;

  assign fx  = px_i[23:8];
  assign fy  = py_i[23:8];
  assign iy  = py_i[31:24];
  assign sqx = fx * fx;
  assign sqy = fy * fy;
  assign ry0 = iy + seed;
  assign ry1 = iy + seed + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_px_r   <= px_i;
      a_py_r   <= py_i;
      a_acc_r  <= acc_i;
      a_fx_r   <= fx;
      a_fy_r   <= fy;
      a_f2x_r  <= sqx[31:16];
      a_f2y_r  <= sqy[31:16];
      a_ix_r   <= px_i[31:24];
      a_row0_r <= PERM_TAB[ry0];
      a_row1_r <= PERM_TAB[ry1];
    end
  end

  // stage b: smoothstep weights and corner hashes
  logic              b_vld_r;
  logic [POS_W-1:0]  b_px_r, b_py_r;
  logic [ACC_W-1:0]  b_acc_r;
  logic [FRAC_W-1:0] b_wx_r, b_wy_r;
  logic [7:0]        b_h00_r, b_h10_r, b_h01_r, b_h11_r;
  logic [17:0]       mx, my;
  logic [33:0]       wpx, wpy;
  logic [7:0]        c00, c10, c01, c11;

  assign mx  = 18'd196608 - {1'b0, a_fx_r, 1'b0};
  assign my  = 18'd196608 - {1'b0, a_fy_r, 1'b0};
  assign wpx = {18'd0, a_f2x_r} * {16'd0, mx};
  assign wpy = {18'd0, a_f2y_r} * {16'd0, my};
  assign c00 = a_row0_r + a_ix_r;
  assign c10 = a_row0_r + a_ix_r + 8'd1;
  assign c01 = a_row1_r + a_ix_r;
  assign c11 = a_row1_r + a_ix_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_px_r  <= a_px_r;
      b_py_r  <= a_py_r;
      b_acc_r <= a_acc_r;
      b_wx_r  <= wpx[31:16];
      b_wy_r  <= wpy[31:16];
      b_h00_r <= PERM_TAB[c00];
      b_h10_r <= PERM_TAB[c10];
      b_h01_r <= PERM_TAB[c01];
      b_h11_r <= PERM_TAB[c11];
    end
  end

  // stage c: horizontal blends
  logic              c_vld_r;
  logic [POS_W-1:0]  c_px_r, c_py_r;
  logic [ACC_W-1:0]  c_acc_r;
  logic [FRAC_W-1:0] c_wy_r;
  logic [VAL_W-1:0]  c_lo_r, c_hi_r;
  logic [16:0]       iwx;
  logic [24:0]       lo_s, hi_s;

  assign iwx  = 17'd65536 - {1'b0, b_wx_r};
  assign lo_s = {17'd0, b_h00_r} * {8'd0, iwx} + {17'd0, b_h10_r} * {9'd0, b_wx_r};
  assign hi_s = {17'd0, b_h01_r} * {8'd0, iwx} + {17'd0, b_h11_r} * {9'd0, b_wx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_px_r  <= b_px_r;
      c_py_r  <= b_py_r;
      c_acc_r <= b_acc_r;
      c_wy_r  <= b_wy_r;
      c_lo_r  <= lo_s[23:0];
      c_hi_r  <= hi_s[23:0];
    end
  end

  // stage d: vertical blend
  logic              d_vld_r;
  logic [POS_W-1:0]  d_px_r, d_py_r;
  logic [ACC_W-1:0]  d_acc_r;
  logic [VAL_W-1:0]  d_v_r;
  logic [16:0]       iwy;
  logic [41:0]       v_s;

  assign iwy = 17'd65536 - {1'b0, c_wy_r};
  assign v_s = {18'd0, c_lo_r} * {25'd0, iwy} + {18'd0, c_hi_r} * {26'd0, c_wy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_px_r  <= c_px_r;
      d_py_r  <= c_py_r;
      d_acc_r <= c_acc_r;
      d_v_r   <= v_s[39:16];
    end
  end

  // stage e: horner step, acc = 2*acc + v for octaves in use
  logic              e_vld_r;
  logic [POS_W-1:0]  e_px_r, e_py_r;
  logic [ACC_W-1:0]  e_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_px_r  <= d_px_r;
      e_py_r  <= d_py_r;
      e_acc_r <= active ? ({d_acc_r[ACC_W-2:0], 1'b0} + ACC_W'(d_v_r)) : d_acc_r;
    end
  end

  // next octave samples at double frequency
  assign vld_o = e_vld_r;
  assign px_o  = {e_px_r[POS_W-2:0], 1'b0};
  assign py_o  = {e_py_r[POS_W-2:0], 1'b0};
  assign acc_o = e_acc_r;

endmodule

>>> hdl/ovn_norm.sv
// normalization: divides the octave sum by 256*(2^n-1) with a reciprocal multiply
// depends on ovn_pkg
module ovn_norm
  import ovn_pkg::*;
#(
  parameter int MAX_OCT = 8,
  parameter int NW      = 4,
  parameter int ACC_W   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [NW-1:0]      oct_n,
  input  logic               vld_i,
  input  logic [ACC_W-1:0]   acc_i,
  output logic               vld_o,
  output logic [NOISE_W-1:0] q_o
);

  localparam int XW = ACC_W - 8;
  localparam int K  = XW;
  localparam int RW = K + 1;
  localparam int H  = RW / 2;

  logic [RW-1:0] recip [MAX_OCT+1];
  assign recip[0] = '0;
  for (genvar g = 1; g <= MAX_OCT; g++) begin : g_recip
    localparam logic [63:0] RV = (64'd1 << K) / ((64'd1 << g) - 64'd1);
    assign recip[g] = RV[RW-1:0];
  end

  // stage 1: partial products of the reciprocal multiply
  logic               s1_vld_r;
  logic [XW-1:0]      s1_x_r;
  logic [XW+RW-H-1:0] s1_pph_r;
  logic [XW+H-1:0]    s1_ppl_r;
  logic [XW-1:0]      x;
  logic [RW-1:0]      r_sel;

  assign x     = acc_i[ACC_W-1:8];
  assign r_sel = recip[oct_n];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r   <= x;
      s1_pph_r <= (XW+RW-H)'(x) * (XW+RW-H)'(r_sel[RW-1:H]);
      s1_ppl_r <= (XW+H)'(x) * (XW+H)'(r_sel[H-1:0]);
    end
  end

  // stage 2: combine into the quotient estimate
  logic               s2_vld_r;
  logic [XW-1:0]      s2_x_r;
  logic [NOISE_W-1:0] s2_q_r;
  logic [XW+RW-1:0]   prod;

  assign prod = {s1_pph_r, {H{1'b0}}} + (XW+RW)'(s1_ppl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x_r <= s1_x_r;
      s2_q_r <= prod[K+NOISE_W-1:K];
    end
  end

  // stage 3: estimate is low by at most one, one compare fixes it
  logic               s3_vld_r;
  logic [NOISE_W-1:0] s3_q_r;
  logic [XW-1:0]      qd, rem, dv;

  assign dv  = (XW'(1) << oct_n) - XW'(1);
  assign qd  = (XW'(s2_q_r) << oct_n) - XW'(s2_q_r);
  assign rem = s2_x_r - qd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_q_r <= (rem >= dv) ? s2_q_r + NOISE_W'(1) : s2_q_r;
    end
  end

  assign vld_o = s3_vld_r;
  assign q_o   = s3_q_r;

endmodule
